>>> rtl/core/gfmsi_pkg.sv
`default_nettype none

package gfmsi_pkg;

  // field and register widths
  localparam int unsigned FieldW = 8;
  localparam int unsigned PolyW  = 9;
  localparam int unsigned FuncW  = 2;

  // low byte of x^8+x^4+x^3+x^2+1, the x^8 term is implied
  localparam logic [FieldW-1:0] PolyLowReset = 8'h1D;

  // one stage per field multiply of the inversion chain
  localparam int unsigned NumStages = 11;

  typedef enum logic [FuncW-1:0] {
    FUNC_MUL  = 2'd0,
    FUNC_SQR  = 2'd1,
    FUNC_INV  = 2'd2,
    FUNC_RSVD = 2'd3
  } func_e;

  // data carried down the pipeline with each word
  typedef struct packed {
    func_e             func;
    logic [FieldW-1:0] acc;  // running result
    logic [FieldW-1:0] opa;  // original operand
    logic [FieldW-1:0] tk;   // a^3, later a^7
    logic [FieldW-1:0] t4;   // a^4
  } stage_t;

endpackage

`default_nettype wire

>>> rtl/core/gfmsi_op_if.sv
`default_nettype none

interface gfmsi_op_if;
  logic                          valid;
  logic                          ready;
  logic [gfmsi_pkg::FuncW-1:0]   func;
  logic [gfmsi_pkg::FieldW-1:0]  operand_a;
  logic [gfmsi_pkg::FieldW-1:0]  operand_b;

  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink (input valid, func, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gfmsi_res_if.sv
`default_nettype none

interface gfmsi_res_if;
  logic                          valid;
  logic                          ready;
  logic [gfmsi_pkg::FieldW-1:0]  product;

  modport source (output valid, product, input ready);
  modport sink (input valid, product, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gfmsi_cfg_if.sv
`default_nettype none

interface gfmsi_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gfmsi_pkg::PolyW-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gfmsi_mul.sv
`default_nettype none

module gfmsi_mul (
  input  wire logic [gfmsi_pkg::FieldW-1:0] a_i,
  input  wire logic [gfmsi_pkg::FieldW-1:0] b_i,
  input  wire logic [gfmsi_pkg::FieldW-1:0] poly_low_i,
  output logic      [gfmsi_pkg::FieldW-1:0] p_o
);

  localparam int unsigned ProdW = 2 * gfmsi_pkg::FieldW - 1;

  logic [ProdW-1:0] clm;
  logic [ProdW-1:0] red;

  // carry-less product
  always_comb begin
    clm = '0;
    for (int j = 0; j < gfmsi_pkg::FieldW; j++) begin
      if (b_i[j]) begin
        clm = clm ^ ({{(ProdW - gfmsi_pkg::FieldW){1'b0}}, a_i} << j);
      end
    end
  end

  // fold the high bits back, top bit first
  always_comb begin
    red = clm;
    for (int i = ProdW - 1; i >= gfmsi_pkg::FieldW; i--) begin
      if (red[i]) begin
        red[i -: (gfmsi_pkg::FieldW + 1)] = red[i -: (gfmsi_pkg::FieldW + 1)] ^
                                            {1'b1, poly_low_i};
      end
    end
  end

  assign p_o = red[gfmsi_pkg::FieldW-1:0];

endmodule

`default_nettype wire

>>> rtl/core/gf256_mul_square_inverse.sv
// GF(2^8) multiply, square and inverse unit. Each word on the op channel carries
// func (0 multiply, 1 square, 2 inverse, 3 gives zero) and one or two bytes;
// each gives exactly one byte on the result channel, in order. The unit is an
// 11-stage pipeline, one field multiplier per stage, sized by the eleven
// multiplies of the inversion chain a^254; every operation takes the same path.
// The first stage register loads at the accepting edge and the word then passes
// through the later stage registers; a new word can be taken every cycle unless
// a result-side stall has filled the pipeline. Stalls on the result side back up
// only as far as the pipeline is full. The reduction polynomial low byte comes
// from the config channel (bit 8 is ignored, x^8 is always implied) and resets to
// 0x1D; write it only while the pipeline is empty. Inverse of zero is zero.
`default_nettype none

module gf256_mul_square_inverse (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  gfmsi_op_if.sink         in_i,
  gfmsi_res_if.source      out_o,
  gfmsi_cfg_if.sink        cfg_i
);

  localparam int unsigned NS = gfmsi_pkg::NumStages;

  logic [gfmsi_pkg::FieldW-1:0] poly_q;

  gfmsi_pkg::stage_t st_q [NS];
  gfmsi_pkg::stage_t st_d [NS];
  logic [NS-1:0]     vld_q;
  logic [NS-1:0]     adv;

  logic [gfmsi_pkg::FieldW-1:0] mx [NS];
  logic [gfmsi_pkg::FieldW-1:0] my [NS];
  logic [gfmsi_pkg::FieldW-1:0] mp [NS];

  gfmsi_pkg::func_e in_func;

  assign in_func = gfmsi_pkg::func_e'(in_i.func);

  // config register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= gfmsi_pkg::PolyLowReset;
    end else if (cfg_i.valid) begin
      poly_q <= cfg_i.data[gfmsi_pkg::FieldW-1:0];
    end
  end

  // a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || out_o.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign in_i.ready = adv[0];

  // one multiplier per stage
  for (genvar g = 0; g < NS; g++) begin : g_mul
    gfmsi_mul u_mul (
      .a_i        (mx[g]),
      .b_i        (my[g]),
      .poly_low_i (poly_q),
      .p_o        (mp[g])
    );
  end

  // first stage: product or square, also a^2 for the inverse
  always_comb begin
    mx[0]         = in_i.operand_a;
    my[0]         = (in_func == gfmsi_pkg::FUNC_MUL) ? in_i.operand_b : in_i.operand_a;
    st_d[0].func  = in_func;
    st_d[0].acc   = (in_func == gfmsi_pkg::FUNC_RSVD) ? '0 : mp[0];
    st_d[0].opa   = in_i.operand_a;
    st_d[0].tk    = in_i.operand_a;
    st_d[0].t4    = in_i.operand_a;
  end

  // later stages: inversion chain 3 4 7 11 15 30 60 120 127 254
  for (genvar g = 1; g < NS; g++) begin : g_chain
    logic inv;
    assign inv = (st_q[g-1].func == gfmsi_pkg::FUNC_INV);

    always_comb begin
      st_d[g] = st_q[g-1];
      mx[g]   = st_q[g-1].acc;
      my[g]   = st_q[g-1].acc;
      unique case (g)
        1: begin
          // a^3 = a^2 * a
          my[g] = st_q[g-1].opa;
          if (inv) st_d[g].tk = mp[g];
        end
        2: begin
          // a^4 = (a^2)^2
          if (inv) begin
            st_d[g].acc = mp[g];
            st_d[g].t4  = mp[g];
          end
        end
        3: begin
          // a^7 = a^4 * a^3
          my[g] = st_q[g-1].tk;
          if (inv) begin
            st_d[g].acc = mp[g];
            st_d[g].tk  = mp[g];
          end
        end
        4, 5: begin
          // a^11 = a^4 * a^7, a^15 = a^11 * a^4
          my[g] = st_q[g-1].t4;
          if (inv) st_d[g].acc = mp[g];
        end
        9: begin
          // a^127 = a^120 * a^7
          my[g] = st_q[g-1].tk;
          if (inv) st_d[g].acc = mp[g];
        end
        default: begin
          // plain squaring steps
          if (inv) st_d[g].acc = mp[g];
        end
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_i.valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv[0] && in_i.valid) st_q[0] <= st_d[0];
    for (int i = 1; i < NS; i++) begin
      if (adv[i] && vld_q[i-1]) st_q[i] <= st_d[i];
    end
  end

  assign out_o.valid   = vld_q[NS-1];
  assign out_o.product = st_q[NS-1].acc;

  // a stalled input means every stage holds a word
  a_full_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  // an accepted word lands in the first stage
  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (vld_q[0] && (st_q[0].func == $past(in_func))))
    else $error("accepted word missing from first stage");

  // unused function code yields zero
  a_rsvd_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NS-1] && (st_q[NS-1].func == gfmsi_pkg::FUNC_RSVD)) |-> (out_o.product == '0))
    else $error("unused function code gave a non-zero result");

  // a held result keeps its value
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NS-1] && !out_o.ready) |=> (vld_q[NS-1] && $stable(st_q[NS-1].acc)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

>>> verif/tb_gf256_mul_square_inverse.sv
`timescale 1ns / 100ps

module tb_gf256_mul_square_inverse;

  localparam int unsigned FieldW = gfmsi_pkg::FieldW;
  localparam int unsigned PolyW  = gfmsi_pkg::PolyW;

  typedef gfmsi_pkg::func_e func_e;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned TailCycles  = 30;
  localparam int unsigned IdlePercent = 27;
  localparam int unsigned PhaseOps    = 210;
  // window of accepted words in which neither side idles
  localparam int unsigned SteadyFrom  = 600;
  localparam int unsigned SteadyTo    = 900;

  typedef enum logic [1:0] {
    JOB_FIELD_OP,
    JOB_POLY_WRITE,
    JOB_DRAIN
  } job_kind_e;

  typedef struct {
    job_kind_e         kind;
    func_e             func;
    logic [FieldW-1:0] opa;
    logic [FieldW-1:0] opb;
    logic [PolyW-1:0]  poly;
  } job_t;

  typedef struct {
    func_e             func;
    logic [FieldW-1:0] opa;
    logic [FieldW-1:0] opb;
    logic [PolyW-1:0]  poly;
    logic [FieldW-1:0] product;
  } expected_t;

  logic clk_i = 1'b0;
  logic rst_n;

  gfmsi_op_if  op_if ();
  gfmsi_res_if res_if ();
  gfmsi_cfg_if cfg_if ();

  gf256_mul_square_inverse dut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .in_i   (op_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  job_t        pending_jobs_q[$];
  expected_t   expected_products_q[$];
  logic [PolyW-1:0] field_poly;
  int unsigned sent_count;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // carry-less product reduced modulo x^8 + low byte
  function automatic logic [FieldW-1:0] gf_mul(input logic [FieldW-1:0] a,
                                               input logic [FieldW-1:0] b,
                                               input logic [FieldW-1:0] low);
    logic [14:0] acc;
    int i;
    acc = '0;
    for (i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ ({7'd0, a} << i);
      end
    end
    for (i = 14; i >= 8; i--) begin
      if (acc[i]) begin
        acc[i] = 1'b0;
        acc = acc ^ ({7'd0, low} << (i - 8));
      end
    end
    return acc[7:0];
  endfunction

  // a^254 along the chain 1 2 3 4 7 11 15 30 60 120 127 254
  function automatic logic [FieldW-1:0] gf_inverse(input logic [FieldW-1:0] a,
                                                   input logic [FieldW-1:0] low);
    logic [FieldW-1:0] p2, p3, p4, p7, p11, p15, r;
    p2  = gf_mul(a, a, low);
    p3  = gf_mul(p2, a, low);
    p4  = gf_mul(p2, p2, low);
    p7  = gf_mul(p4, p3, low);
    p11 = gf_mul(p4, p7, low);
    p15 = gf_mul(p11, p4, low);
    r   = gf_mul(p15, p15, low);
    r   = gf_mul(r, r, low);
    r   = gf_mul(r, r, low);
    r   = gf_mul(r, p7, low);
    r   = gf_mul(r, r, low);
    return r;
  endfunction

  // expected product for one word, bit 8 of the polynomial is ignored
  function automatic logic [FieldW-1:0] gf_product(input func_e f,
                                                   input logic [FieldW-1:0] a,
                                                   input logic [FieldW-1:0] b,
                                                   input logic [PolyW-1:0] poly);
    logic [FieldW-1:0] r;
    case (f)
      gfmsi_pkg::FUNC_MUL: r = gf_mul(a, b, poly[7:0]);
      gfmsi_pkg::FUNC_SQR: r = gf_mul(a, a, poly[7:0]);
      gfmsi_pkg::FUNC_INV: r = gf_inverse(a, poly[7:0]);
      default:             r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic add_op(input func_e f, input logic [FieldW-1:0] a,
                        input logic [FieldW-1:0] b);
    job_t j;
    j.kind = JOB_FIELD_OP;
    j.func = f;
    j.opa  = a;
    j.opb  = b;
    j.poly = '0;
    pending_jobs_q.push_back(j);
  endtask

  task automatic add_job(input job_kind_e k, input logic [PolyW-1:0] poly);
    job_t j;
    j.kind = k;
    j.func = gfmsi_pkg::FUNC_MUL;
    j.opa  = '0;
    j.opb  = '0;
    j.poly = poly;
    pending_jobs_q.push_back(j);
  endtask

  // operands lean towards zero, one and the top bit now and then
  function automatic logic [FieldW-1:0] pick_operand();
    logic [FieldW-1:0] v;
    case ($urandom_range(15))
      0:       v = 8'h00;
      1:       v = 8'h01;
      2:       v = 8'hFF;
      3:       v = 8'h80;
      default: v = FieldW'($urandom_range(255));
    endcase
    return v;
  endfunction

  task automatic add_random_ops(input int unsigned count, input bit with_drain);
    func_e f;
    int unsigned n;
    int unsigned sel;
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(9);
      if (sel < 3) f = gfmsi_pkg::FUNC_MUL;
      else if (sel < 6) f = gfmsi_pkg::FUNC_SQR;
      else if (sel < 9) f = gfmsi_pkg::FUNC_INV;
      else f = gfmsi_pkg::FUNC_RSVD;
      add_op(f, pick_operand(), pick_operand());
      if (with_drain && n == count / 2) begin
        add_job(JOB_DRAIN, '0);
      end
    end
  endtask

  // driver: one job at the head of the queue at a time
  always @(posedge clk_i or negedge rst_n) begin
    job_t      head;
    expected_t e;
    logic      op_taken, cfg_taken, op_next, cfg_next, steady;
    if (!rst_n) begin
      op_if.valid     <= 1'b0;
      op_if.func      <= gfmsi_pkg::FUNC_MUL;
      op_if.operand_a <= '0;
      op_if.operand_b <= '0;
      cfg_if.valid    <= 1'b0;
      cfg_if.data     <= '0;
      field_poly      <= {1'b1, gfmsi_pkg::PolyLowReset};
      sent_count      <= 0;
    end else begin
      op_taken  = op_if.valid && op_if.ready;
      cfg_taken = cfg_if.valid && cfg_if.ready;
      if (op_taken) begin
        e.func    = func_e'(op_if.func);
        e.opa     = op_if.operand_a;
        e.opb     = op_if.operand_b;
        e.poly    = field_poly;
        e.product = gf_product(e.func, e.opa, e.opb, field_poly);
        expected_products_q.push_back(e);
        void'(pending_jobs_q.pop_front());
        sent_count <= sent_count + 1;
      end
      if (cfg_taken) begin
        field_poly <= cfg_if.data;
        void'(pending_jobs_q.pop_front());
      end
      op_next  = op_if.valid && !op_taken;
      cfg_next = cfg_if.valid && !cfg_taken;
      steady   = (sent_count >= SteadyFrom) && (sent_count < SteadyTo);
      if (!op_next && !cfg_next && pending_jobs_q.size() != 0) begin
        head = pending_jobs_q[0];
        case (head.kind)
          JOB_FIELD_OP: begin
            if (steady || $urandom_range(99) >= IdlePercent) begin
              op_if.func      <= head.func;
              op_if.operand_a <= head.opa;
              op_if.operand_b <= head.opb;
              op_next = 1'b1;
            end
          end
          // polynomial only changes with the pipeline empty
          JOB_POLY_WRITE: begin
            if (expected_products_q.size() == 0) begin
              cfg_if.data <= head.poly;
              cfg_next = 1'b1;
            end
          end
          default: begin
            if (expected_products_q.size() == 0) begin
              void'(pending_jobs_q.pop_front());
            end
          end
        endcase
      end
      op_if.valid  <= op_next;
      cfg_if.valid <= cfg_next;
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk_i or negedge rst_n) begin
    expected_t e;
    logic      steady;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      results_seen <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_products_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word, product %02h", res_if.product));
        end else begin
          e = expected_products_q.pop_front();
          if (res_if.product !== e.product) begin
            report_mismatch($sformatf(
              "product mismatch: func %0d a %02h b %02h poly %03h expected %02h got %02h",
              e.func, e.opa, e.opb, e.poly, e.product, res_if.product));
          end
        end
        results_seen <= results_seen + 1;
      end
      steady = (results_seen >= SteadyFrom) && (results_seen < SteadyTo);
      res_if.ready <= steady || ($urandom_range(99) >= IdlePercent);
    end
  end

  initial begin
    logic [PolyW-1:0] polys[6];
    int unsigned p;
    bit timed_out;
    rst_n = 1'b0;

    // directed words under the reset polynomial
    add_op(gfmsi_pkg::FUNC_MUL, 8'h00, 8'h00);
    add_op(gfmsi_pkg::FUNC_MUL, 8'hFF, 8'hFF);
    add_op(gfmsi_pkg::FUNC_MUL, 8'h01, 8'hA7);
    add_op(gfmsi_pkg::FUNC_MUL, 8'h80, 8'h80);
    add_op(gfmsi_pkg::FUNC_MUL, 8'hAA, 8'h55);
    add_op(gfmsi_pkg::FUNC_MUL, 8'h00, 8'hFF);
    add_op(gfmsi_pkg::FUNC_SQR, 8'h00, 8'hFF);
    add_op(gfmsi_pkg::FUNC_SQR, 8'hFF, 8'h00);
    add_op(gfmsi_pkg::FUNC_SQR, 8'h80, 8'h5A);
    add_op(gfmsi_pkg::FUNC_INV, 8'h00, 8'hFF);
    add_op(gfmsi_pkg::FUNC_INV, 8'h01, 8'h00);
    add_op(gfmsi_pkg::FUNC_INV, 8'h02, 8'h00);
    add_op(gfmsi_pkg::FUNC_INV, 8'hFF, 8'h00);
    add_op(gfmsi_pkg::FUNC_INV, 8'h53, 8'hCA);
    // unused selector gives zero whatever the operands
    add_op(gfmsi_pkg::FUNC_RSVD, 8'hFF, 8'hFF);
    add_op(gfmsi_pkg::FUNC_RSVD, 8'h00, 8'h00);
    add_op(gfmsi_pkg::FUNC_RSVD, 8'h5A, 8'hA5);

    // phases over several polynomials: reducible, bit 8 clear, extremes
    polys[0] = 9'h11B;
    polys[1] = 9'h1FF;
    polys[2] = 9'h000;
    polys[3] = 9'h100;
    polys[4] = PolyW'($urandom_range(511));
    polys[5] = 9'h11D;
    add_random_ops(PhaseOps, 1'b1);
    for (p = 0; p < 6; p++) begin
      add_job(JOB_POLY_WRITE, polys[p]);
      add_random_ops(PhaseOps, p == 2);
    end

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;

    while ((pending_jobs_q.size() != 0 || expected_products_q.size() != 0)
           && cycle_count < CycleLimit) begin
      @(posedge clk_i);
    end
    timed_out = (cycle_count >= CycleLimit);
    if (!timed_out) begin
      repeat (TailCycles) @(posedge clk_i);
      if (expected_products_q.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", expected_products_q.size()));
      end
    end

    if (timed_out) begin
      $display("Regression FAIL");
    end else if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
